FILE: src/dtti_pkg.sv
// ----------------------------------------------------------------------------
// dtti_pkg: shared types and constants for the decimal text converter
// Character codes, mode limits, status codes and the records passed
// between the input register, the scanner and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package dtti_pkg;

   // result modes
   localparam logic [1:0] MODE_S32 = 2'd0;
   localparam logic [1:0] MODE_U32 = 2'd1;
   localparam logic [1:0] MODE_S64 = 2'd2;
   localparam logic [1:0] MODE_U64 = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [63:0] LIMIT_S32 = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] LIMIT_U32 = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] LIMIT_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIMIT_U64 = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic [63:0] LIMIT_S32_DIV10 = LIMIT_S32 / 10;
   localparam logic [63:0] LIMIT_U32_DIV10 = LIMIT_U32 / 10;
   localparam logic [63:0] LIMIT_S64_DIV10 = LIMIT_S64 / 10;
   localparam logic [63:0] LIMIT_U64_DIV10 = LIMIT_U64 / 10;

   localparam logic [3:0] LIMIT_S32_MOD10 = 4'(LIMIT_S32 % 10);
   localparam logic [3:0] LIMIT_U32_MOD10 = 4'(LIMIT_U32 % 10);
   localparam logic [3:0] LIMIT_S64_MOD10 = 4'(LIMIT_S64 % 10);
   localparam logic [3:0] LIMIT_U64_MOD10 = 4'(LIMIT_U64 % 10);

   typedef struct packed {
      logic       valid;
      logic [7:0] char_in;
      logic       last_char;
   } char_item_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] value_out;
      logic [1:0]  status;
   } result_item_type;

   typedef struct packed {
      logic [63:0] magnitude_acc;
      logic        token_overflow;
      logic        token_bad_char;
      logic        token_negative;
      logic        prior_nonspace_minus;
      logic        inside_token;
      logic        seen_nonspace;
   } scan_state_type;

   function automatic logic [63:0] mode_limit(input logic [1:0] mode);
      logic [63:0] lim;
      unique case (mode)
         MODE_S32: lim = LIMIT_S32;
         MODE_U32: lim = LIMIT_U32;
         MODE_S64: lim = LIMIT_S64;
         default:  lim = LIMIT_U64;
      endcase
      return lim;
   endfunction

   function automatic logic [63:0] mode_limit_div10(input logic [1:0] mode);
      logic [63:0] lim;
      unique case (mode)
         MODE_S32: lim = LIMIT_S32_DIV10;
         MODE_U32: lim = LIMIT_U32_DIV10;
         MODE_S64: lim = LIMIT_S64_DIV10;
         default:  lim = LIMIT_U64_DIV10;
      endcase
      return lim;
   endfunction

   function automatic logic [3:0] mode_limit_mod10(input logic [1:0] mode);
      logic [3:0] rem;
      unique case (mode)
         MODE_S32: rem = LIMIT_S32_MOD10;
         MODE_U32: rem = LIMIT_U32_MOD10;
         MODE_S64: rem = LIMIT_S64_MOD10;
         default:  rem = LIMIT_U64_MOD10;
      endcase
      return rem;
   endfunction

endpackage

`default_nettype wire

FILE: src/dtti_if.sv
// ----------------------------------------------------------------------------
// dtti_if: channel interfaces for the decimal text converter
// Character channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtti_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last_char;

   modport source (output valid, output char_in, output last_char, input ready);
   modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface dtti_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value_out;
   logic [1:0]  status;

   modport source (output valid, output value_out, output status, input ready);
   modport sink   (input valid, input value_out, input status, output ready);
endinterface

`default_nettype wire

FILE: src/dtti_in_reg.sv
// ----------------------------------------------------------------------------
// dtti_in_reg: character input register
// Holds one accepted character until the scanner takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtti_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   dtti_req_if.sink               req_chan,
   input  wire logic              take,
   output dtti_pkg::char_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_chan.char_in;
         last_ff <= req_chan.last_char;
      end
   end

   assign item.valid     = valid_ff;
   assign item.char_in   = char_ff;
   assign item.last_char = last_ff;

`ifndef ASSERT_OFF
   // a held item stays put until the scanner takes it
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !take) |=> (valid_ff && $stable(char_ff) && $stable(last_ff)))
      else $error("input register lost or changed an untaken item");
`endif

endmodule

`default_nettype wire

FILE: src/dtti_scan.sv
// ----------------------------------------------------------------------------
// dtti_scan: token scanner and result builder
// Updates the token state with one character a cycle (a last one only
// when out_free) and forms value and status on a string's last character.
// ----------------------------------------------------------------------------
`default_nettype none

module dtti_scan (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_en,
   input  wire logic [1:0]              csr_write_data,
   input  wire dtti_pkg::char_item_type item,
   input  wire logic                    out_free,
   output logic                         take,
   output dtti_pkg::result_item_type    result
);

   logic [1:0]               mode_ff;
   dtti_pkg::scan_state_type state_ff, state_in, upd;

   logic [7:0]  c;
   logic        is_white, is_sign, is_digit, is_minus;
   logic [3:0]  digit;
   logic [63:0] base_acc;
   logic        base_ovf;
   logic [63:0] lim, lim_div10;
   logic [3:0]  lim_mod10;
   logic [63:0] mag_neg;

   assign c        = item.char_in;
   assign is_white = ((c >= dtti_pkg::CHAR_TAB) && (c <= dtti_pkg::CHAR_CR))
                     || (c == dtti_pkg::CHAR_SPACE);
   assign is_minus = (c == dtti_pkg::CHAR_MINUS);
   assign is_sign  = (c == dtti_pkg::CHAR_PLUS) || is_minus;
   assign is_digit = (c >= dtti_pkg::CHAR_ZERO) && (c <= dtti_pkg::CHAR_NINE);
   assign digit    = c[3:0];

   assign lim       = dtti_pkg::mode_limit(mode_ff);
   assign lim_div10 = dtti_pkg::mode_limit_div10(mode_ff);
   assign lim_mod10 = dtti_pkg::mode_limit_mod10(mode_ff);

   // a last character waits while the result register is occupied
   assign take = item.valid && (!item.last_char || out_free);

   // a new token restarts the digit run
   assign base_acc = state_ff.inside_token ? state_ff.magnitude_acc : 64'd0;
   assign base_ovf = state_ff.inside_token ? state_ff.token_overflow : 1'b0;

   always_comb begin
      upd = state_ff;
      if (is_white) begin
         upd.inside_token = 1'b0;
      end else if (is_sign) begin
         upd.magnitude_acc        = 64'd0;
         upd.token_overflow       = 1'b0;
         upd.token_bad_char       = 1'b0;
         upd.token_negative       = is_minus;
         upd.inside_token         = 1'b0;
         upd.prior_nonspace_minus = is_minus;
         upd.seen_nonspace        = 1'b1;
      end else begin
         upd.magnitude_acc  = base_acc;
         upd.token_overflow = base_ovf;
         if (!state_ff.inside_token) begin
            upd.token_bad_char = 1'b0;
            upd.token_negative = state_ff.prior_nonspace_minus;
         end
         upd.inside_token = 1'b1;
         if (is_digit) begin
            if (!base_ovf) begin
               if ((base_acc > lim_div10) ||
                   ((base_acc == lim_div10) && (digit > lim_mod10))) begin
                  upd.token_overflow = 1'b1;
               end else begin
                  // times ten as two shifts and an add
                  upd.magnitude_acc = (base_acc << 3) + (base_acc << 1)
                                      + {60'd0, digit};
               end
            end
         end else begin
            upd.token_bad_char = 1'b1;
            upd.magnitude_acc  = 64'd0;
            upd.token_overflow = 1'b0;
         end
         upd.prior_nonspace_minus = 1'b0;
         upd.seen_nonspace        = 1'b1;
      end
   end

   assign mag_neg = 64'd0 - upd.magnitude_acc;

   always_comb begin
      result.valid     = take && item.last_char;
      result.value_out = 64'd0;
      if (!upd.seen_nonspace) begin
         result.status = dtti_pkg::STATUS_INVALID;
      end else if (upd.token_overflow || (upd.magnitude_acc > lim)) begin
         result.status = dtti_pkg::STATUS_OVERFLOW;
      end else if (upd.token_bad_char) begin
         result.status = dtti_pkg::STATUS_INVALID;
      end else begin
         result.status    = dtti_pkg::STATUS_OK;
         result.value_out = upd.token_negative ? mag_neg : upd.magnitude_acc;
         if (!mode_ff[1]) begin
            result.value_out[63:32] = 32'd0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      if (take) begin
         state_in = item.last_char ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         mode_ff  <= dtti_pkg::MODE_S32;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            mode_ff <= csr_write_data;
         end
      end
   end

`ifndef ASSERT_OFF
   // every string starts from a clean state
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && item.last_char) |=> (state_ff == '0))
      else $error("token state not cleared after last character");

   // any error status carries a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (result.valid && (result.status != dtti_pkg::STATUS_OK))
      |-> (result.value_out == 64'd0))
      else $error("error result with nonzero value");

   // 32-bit modes never set the upper half
   a_narrow_mode: assert property (@(posedge clock) disable iff (reset)
      (result.valid && !mode_ff[1]) |-> (result.value_out[63:32] == 32'd0))
      else $error("upper half set in 32-bit mode");
`endif

endmodule

`default_nettype wire

FILE: src/dtti_out_reg.sv
// ----------------------------------------------------------------------------
// dtti_out_reg: result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtti_out_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dtti_pkg::result_item_type result,
   output logic                           out_free,
   dtti_rsp_if.source                     rsp_chan
);

   logic        valid_ff, valid_in;
   logic [63:0] value_ff;
   logic [1:0]  status_ff;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         value_ff  <= result.value_out;
         status_ff <= result.status;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.value_out = value_ff;
   assign rsp_chan.status    = status_ff;

`ifndef ASSERT_OFF
   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (!valid_ff || rsp_chan.ready))
      else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

FILE: src/decimal_text_to_integer.sv
// ----------------------------------------------------------------------------
// decimal_text_to_integer: decimal text to binary integer converter
// Scans a string one character per item and gives value and status on the
// item flagged last.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one character per item with last_char marking the end
//   of a string. rsp_chan carries one result (value_out, status) per string,
//   produced by the last character; other characters produce no result.
//   csr_write_data sets the result mode on a cycle with csr_write_en high;
//   write it only while no string is in flight.
// Timing:
//   one character is accepted every cycle while no last character stalls.
//   A character is held in the input register, where the scanner folds it
//   into the token state; a last character then loads the result register,
//   which presents the result on rsp_chan.
//   The per-character step is a times-ten shift-add and a limit compare.
// Reset:
//   clears the token state, both registers' valid flags and sets the mode
//   to signed 32-bit.
// Stall:
//   while a result waits, non-last characters keep flowing; a last
//   character waits in the input register until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_integer (
   input  wire logic       clock,
   input  wire logic       reset,
   dtti_req_if.sink        req_chan,
   dtti_rsp_if.source      rsp_chan,
   input  wire logic       csr_write_en,
   input  wire logic [1:0] csr_write_data
);

   dtti_pkg::char_item_type   item;
   dtti_pkg::result_item_type result;
   logic                      take;
   logic                      out_free;

   dtti_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .item     (item)
   );

   dtti_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .item           (item),
      .out_free       (out_free),
      .take           (take),
      .result         (result)
   );

   dtti_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
